FILE: rtl/tsl_pkg.sv
`default_nettype none

package tsl_pkg;

  // Batch accumulator sizing
  localparam int unsigned MAX_TRACKS = 1024;
  localparam int unsigned CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int unsigned SPD_W      = 31;
  localparam int unsigned SUM_W      = SPD_W + CNT_W;

  // Shared divide / square root unit
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned ITER_W = 7;

  // Operand widths of the individual divisions
  localparam int unsigned VEL_NUM_W   = 41;
  localparam int unsigned CLAMP_NUM_W = 63;
  localparam int unsigned ROOT_ITERS  = 32;

  // 1/16 px per us to 1/256 px per s
  localparam logic [23:0] VEL_SCALE = 24'd16000000;

  // Configuration register indexes
  localparam logic [2:0] REG_FRAME_PREV  = 3'd0;
  localparam logic [2:0] REG_FRAME_LAST  = 3'd1;
  localparam logic [2:0] REG_TIME_FIRST  = 3'd2;
  localparam logic [2:0] REG_TIME_SECOND = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED   = 3'd4;
  localparam logic [2:0] REG_LIMIT_MODE  = 3'd5;
  localparam logic [2:0] REG_MAX_GAP     = 3'd6;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } tsl_op_e;

  typedef struct packed {
    logic              start;
    tsl_op_e           op;
    logic [ITER_W-1:0] iters;
  } tsl_iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tsl_iter_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DIVW,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ROOTW,
    ST_CMUL,
    ST_CDIV,
    ST_CDIVW,
    ST_FIN,
    ST_MEANW,
    ST_DONE
  } tsl_state_e;

endpackage

`default_nettype wire

FILE: rtl/tsl_iter_unit.sv
`default_nettype none

// Restoring divider and digit-by-digit square root on one subtractor.
module tsl_iter_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire tsl_pkg::tsl_iter_req_t  req_i,
  input  wire  [tsl_pkg::NUM_W-1:0]    num_i,
  input  wire  [tsl_pkg::DEN_W-1:0]    den_i,
  output tsl_pkg::tsl_iter_rsp_t       rsp_o,
  output logic [tsl_pkg::NUM_W-1:0]    quo_o,
  output logic [tsl_pkg::REM_W-1:0]    rem_o
);

  logic [tsl_pkg::NUM_W-1:0]  num_q;
  logic [tsl_pkg::DEN_W-1:0]  den_q;
  logic [tsl_pkg::NUM_W-1:0]  quo_q;
  logic [tsl_pkg::REM_W-1:0]  rem_q;
  logic [tsl_pkg::ITER_W-1:0] cnt_q;
  tsl_pkg::tsl_op_e           op_q;
  logic                       busy_q;
  logic                       done_q;

  logic [tsl_pkg::REM_W-1:0]  opa;
  logic [tsl_pkg::REM_W-1:0]  opb;
  logic [tsl_pkg::REM_W:0]    diff;
  logic                       ge;

  // Form the trial subtraction for one step
  always_comb begin
    if (op_q == tsl_pkg::OP_SQRT) begin
      opa = {rem_q[tsl_pkg::REM_W-3:0], num_q[tsl_pkg::NUM_W-1 -: 2]};
      opb = {quo_q[tsl_pkg::REM_W-3:0], 2'b01};
    end else begin
      opa = {rem_q[tsl_pkg::REM_W-2:0], num_q[tsl_pkg::NUM_W-1]};
      opb = tsl_pkg::REM_W'(den_q);
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[tsl_pkg::REM_W];
  end

  // Control: busy and done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tsl_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit or one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      op_q  <= req_i.op;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[tsl_pkg::REM_W-1:0] : opa;
      quo_q <= {quo_q[tsl_pkg::NUM_W-2:0], ge};
      if (op_q == tsl_pkg::OP_SQRT) begin
        num_q <= {num_q[tsl_pkg::NUM_W-3:0], 2'b00};
      end else begin
        num_q <= {num_q[tsl_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quo_o      = quo_q;
  assign rem_o      = rem_q;

endmodule

`default_nettype wire

FILE: rtl/track_speed_limiter_core.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata frames+coords, tuser has_two,
//                                                 tlast batch_end
// m_axis    out        m_axis_tvalid/tready       tdata vel_x, vel_y, mean_speed,
//                                                 tuser matched, batch_invalid, tlast
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// A matched item runs two velocity divisions and a square root, plus two clamp
// divisions and a second root when clamped; a valid, non-empty batch end adds the
// mean division. The shared unit works one bit (or root digit) per cycle.
// Reset clears config to defaults and the batch count and sum; a result waits in
// the output register until taken, and the next item is accepted once it is loaded.
module track_speed_limiter_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // newest_frame, older_frame, older_x, older_y, newest_x, newest_y
  input  wire  [127:0] s_axis_tdata_i,
  // has_two
  input  wire  [0:0]   s_axis_tuser_i,
  input  wire          s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // vel_x, vel_y, mean_speed, zero pad
  output logic [95:0]  m_axis_tdata_o,
  // matched, batch_invalid
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i
);

  // Configuration
  logic [31:0] frame_prev_q, frame_last_q, time_first_q, time_second_q, max_gap_q;
  logic [30:0] max_speed_q;
  logic        limit_q;

  // Item and working registers
  tsl_pkg::tsl_state_e           state_q, state_d;
  logic [15:0]                   ox_q, oy_q, nx_q, ny_q;
  logic                          last_q, matched_q, invalid_q, negt_q, neg_q;
  logic [31:0]                   gap_q;
  logic                          comp_q, clamped_q;
  logic [tsl_pkg::CLAMP_NUM_W-1:0] prod_q;
  logic [63:0]                   sq_q;
  logic [31:0]                   vx_q, vy_q, mag_q;
  logic [30:0]                   mean_q;
  logic [tsl_pkg::CNT_W-1:0]     count_q;
  logic [tsl_pkg::SUM_W-1:0]     sum_q;
  logic                          ovalid_q;
  logic [95:0]                   odata_q;
  logic [1:0]                    ouser_q;
  logic                          olast_q;

  // Shared unit
  tsl_pkg::tsl_iter_req_t        req;
  tsl_pkg::tsl_iter_rsp_t        rsp;
  logic [tsl_pkg::NUM_W-1:0]     unit_num, unit_quo;
  logic [tsl_pkg::DEN_W-1:0]     unit_den;
  logic [tsl_pkg::REM_W-1:0]     unit_rem;

  logic        in_fire, out_go;
  logic [32:0] dt_w;
  logic [31:0] gap_w;
  logic        invalid_w, matched_w;
  logic [16:0] dx_w;
  logic [15:0] adx_w;
  logic [31:0] v_cur, av_cur, ax_w, ay_w;
  logic [31:0] mag_w, vsat_w;
  logic        go_clamp;
  logic [30:0] spd_w;
  logic [63:0] vel_num, clamp_num, mean_num;

  function automatic logic [31:0] sat_vel(input logic [63:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  assign s_axis_tready_o = (state_q == tsl_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_go          = ~ovalid_q | m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  // Time checks and frame match
  always_comb begin
    dt_w  = {1'b0, time_second_q} - {1'b0, time_first_q};
    gap_w = dt_w[32] ? (32'd0 - dt_w[31:0]) : dt_w[31:0];
    if (limit_q) begin
      invalid_w = (dt_w == 33'd0) || (time_second_q == 32'd0) || (gap_w > max_gap_q);
    end else begin
      invalid_w = (dt_w == 33'd0) || (time_first_q == 32'd0) || (time_second_q == 32'd0);
    end
    matched_w = s_axis_tuser_i[0] && (s_axis_tdata_i[31:0] == frame_last_q)
                && (s_axis_tdata_i[63:32] == frame_prev_q);
  end

  // Operand selection for the current component
  always_comb begin
    dx_w   = comp_q ? ({1'b0, ny_q} - {1'b0, oy_q}) : ({1'b0, nx_q} - {1'b0, ox_q});
    adx_w  = dx_w[16] ? 16'(17'd0 - dx_w) : dx_w[15:0];
    v_cur  = comp_q ? vy_q : vx_q;
    av_cur = abs32(v_cur);
    ax_w   = abs32(vx_q);
    ay_w   = abs32(vy_q);
    mag_w  = unit_quo[31:0] + 32'((unit_rem > tsl_pkg::REM_W'(unit_quo[31:0])) ? 1 : 0);
    vsat_w = sat_vel(unit_quo, neg_q);
    go_clamp = limit_q && !clamped_q && (mag_w > {1'b0, max_speed_q});
    spd_w  = (mag_w > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : mag_w[30:0];
    vel_num   = (64'(prod_q) + 64'(gap_q >> 1)) << (tsl_pkg::NUM_W - tsl_pkg::VEL_NUM_W);
    clamp_num = (64'(prod_q) + 64'(mag_q >> 1)) << (tsl_pkg::NUM_W - tsl_pkg::CLAMP_NUM_W);
    mean_num  = (64'(sum_q) + 64'(count_q >> 1)) << (tsl_pkg::NUM_W - tsl_pkg::SUM_W);
  end

  // Sequencer: next state and unit requests
  always_comb begin
    state_d   = state_q;
    req.start = 1'b0;
    req.op    = tsl_pkg::OP_DIV;
    req.iters = '0;
    unit_num  = '0;
    unit_den  = '0;
    unique case (state_q)
      tsl_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (matched_w && !invalid_w) ? tsl_pkg::ST_MUL : tsl_pkg::ST_FIN;
        end
      end
      tsl_pkg::ST_MUL: state_d = tsl_pkg::ST_DIV;
      tsl_pkg::ST_DIV: begin
        req.start = 1'b1;
        req.iters = tsl_pkg::ITER_W'(tsl_pkg::VEL_NUM_W);
        unit_num  = vel_num;
        unit_den  = gap_q;
        state_d   = tsl_pkg::ST_DIVW;
      end
      tsl_pkg::ST_DIVW: begin
        if (rsp.done) begin
          state_d = comp_q ? tsl_pkg::ST_SQX : tsl_pkg::ST_MUL;
        end
      end
      tsl_pkg::ST_SQX: state_d = tsl_pkg::ST_SQY;
      tsl_pkg::ST_SQY: state_d = tsl_pkg::ST_ROOT;
      tsl_pkg::ST_ROOT: begin
        req.start = 1'b1;
        req.op    = tsl_pkg::OP_SQRT;
        req.iters = tsl_pkg::ITER_W'(tsl_pkg::ROOT_ITERS);
        unit_num  = sq_q;
        state_d   = tsl_pkg::ST_ROOTW;
      end
      tsl_pkg::ST_ROOTW: begin
        if (rsp.done) begin
          state_d = go_clamp ? tsl_pkg::ST_CMUL : tsl_pkg::ST_FIN;
        end
      end
      tsl_pkg::ST_CMUL: state_d = tsl_pkg::ST_CDIV;
      tsl_pkg::ST_CDIV: begin
        req.start = 1'b1;
        req.iters = tsl_pkg::ITER_W'(tsl_pkg::CLAMP_NUM_W);
        unit_num  = clamp_num;
        unit_den  = mag_q;
        state_d   = tsl_pkg::ST_CDIVW;
      end
      tsl_pkg::ST_CDIVW: begin
        if (rsp.done) begin
          state_d = comp_q ? tsl_pkg::ST_SQX : tsl_pkg::ST_CMUL;
        end
      end
      tsl_pkg::ST_FIN: begin
        if (last_q && !invalid_q && (count_q != '0)) begin
          req.start = 1'b1;
          req.iters = tsl_pkg::ITER_W'(tsl_pkg::SUM_W);
          unit_num  = mean_num;
          unit_den  = tsl_pkg::DEN_W'(count_q);
          state_d   = tsl_pkg::ST_MEANW;
        end else begin
          state_d = tsl_pkg::ST_DONE;
        end
      end
      tsl_pkg::ST_MEANW: begin
        if (rsp.done) begin
          state_d = tsl_pkg::ST_DONE;
        end
      end
      tsl_pkg::ST_DONE: begin
        if (out_go) begin
          state_d = tsl_pkg::ST_IDLE;
        end
      end
      default: state_d = tsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_prev_q  <= '0;
      frame_last_q  <= '0;
      time_first_q  <= '0;
      time_second_q <= '0;
      max_speed_q   <= '0;
      limit_q       <= 1'b1;
      max_gap_q     <= 32'd1000000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tsl_pkg::REG_FRAME_PREV:  frame_prev_q  <= cfg_data_i;
        tsl_pkg::REG_FRAME_LAST:  frame_last_q  <= cfg_data_i;
        tsl_pkg::REG_TIME_FIRST:  time_first_q  <= cfg_data_i;
        tsl_pkg::REG_TIME_SECOND: time_second_q <= cfg_data_i;
        tsl_pkg::REG_MAX_SPEED:   max_speed_q   <= cfg_data_i[30:0];
        tsl_pkg::REG_LIMIT_MODE:  limit_q       <= cfg_data_i[0];
        tsl_pkg::REG_MAX_GAP:     max_gap_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control flags and batch accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q    <= 1'b0;
      clamped_q <= 1'b0;
      count_q   <= '0;
      sum_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        comp_q    <= 1'b0;
        clamped_q <= 1'b0;
      end
      // advance component after each velocity division
      if ((state_q == tsl_pkg::ST_DIVW || state_q == tsl_pkg::ST_CDIVW) && rsp.done) begin
        comp_q <= ~comp_q;
        if (state_q == tsl_pkg::ST_CDIVW && comp_q) begin
          clamped_q <= 1'b1;
        end
      end
      // add the final speed while the batch still has room
      if (state_q == tsl_pkg::ST_ROOTW && rsp.done && !go_clamp
          && (count_q < tsl_pkg::CNT_W'(tsl_pkg::MAX_TRACKS))) begin
        count_q <= count_q + 1'b1;
        sum_q   <= sum_q + tsl_pkg::SUM_W'(spd_w);
      end
      // clear after the last item of a batch
      if ((state_q == tsl_pkg::ST_FIN && state_d == tsl_pkg::ST_DONE && last_q)
          || (state_q == tsl_pkg::ST_MEANW && rsp.done)) begin
        count_q <= '0;
        sum_q   <= '0;
      end
      if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == tsl_pkg::ST_DONE && out_go) begin
        ovalid_q <= 1'b1;
      end
    end
  end

  // Payload datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      nx_q      <= s_axis_tdata_i[111:96];
      ny_q      <= s_axis_tdata_i[127:112];
      ox_q      <= s_axis_tdata_i[79:64];
      oy_q      <= s_axis_tdata_i[95:80];
      last_q    <= s_axis_tlast_i;
      matched_q <= matched_w;
      invalid_q <= invalid_w;
      negt_q    <= dt_w[32];
      gap_q     <= gap_w;
      vx_q      <= '0;
      vy_q      <= '0;
      mean_q    <= '0;
    end
    if (state_q == tsl_pkg::ST_MUL) begin
      prod_q <= tsl_pkg::CLAMP_NUM_W'(adx_w * tsl_pkg::VEL_SCALE);
      neg_q  <= dx_w[16] ^ negt_q;
    end
    if (state_q == tsl_pkg::ST_CMUL) begin
      prod_q <= tsl_pkg::CLAMP_NUM_W'(av_cur * max_speed_q);
      neg_q  <= v_cur[31];
    end
    if ((state_q == tsl_pkg::ST_DIVW || state_q == tsl_pkg::ST_CDIVW) && rsp.done) begin
      if (comp_q) begin
        vy_q <= vsat_w;
      end else begin
        vx_q <= vsat_w;
      end
    end
    if (state_q == tsl_pkg::ST_SQX) begin
      sq_q <= ax_w * ax_w;
    end
    if (state_q == tsl_pkg::ST_SQY) begin
      sq_q <= sq_q + (ay_w * ay_w);
    end
    if (state_q == tsl_pkg::ST_ROOTW && rsp.done) begin
      mag_q <= mag_w;
    end
    if (state_q == tsl_pkg::ST_MEANW && rsp.done) begin
      mean_q <= (unit_quo > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : unit_quo[30:0];
    end
    // load the output register
    if (state_q == tsl_pkg::ST_DONE && out_go) begin
      odata_q <= {1'b0, mean_q, vy_q, vx_q};
      ouser_q <= {invalid_q, matched_q};
      olast_q <= last_q;
    end
  end

  tsl_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .num_i  (unit_num),
    .den_i  (unit_den),
    .rsp_o  (rsp),
    .quo_o  (unit_quo),
    .rem_o  (unit_rem)
  );

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

`default_nettype wire

FILE: dv/tb_track_speed_limiter_core.sv
`default_nettype none

module tb_track_speed_limiter_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    bit        has_two;
    bit [31:0] newest_frame;
    bit [31:0] older_frame;
    bit [15:0] ox, oy, nx, ny;
    bit        batch_end;
  } track_t;

  typedef struct {
    bit [31:0] vel_x;
    bit [31:0] vel_y;
    bit        matched;
    bit [30:0] mean_speed;
    bit        invalid;
    bit        last;
  } speed_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [127:0] s_data = '0;
  logic [0:0]   s_user = '0;
  logic         s_last = 1'b0;
  logic         m_ready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  wire          s_axis_tready_o;
  wire          m_axis_tvalid_o;
  wire [95:0]   m_axis_tdata_o;
  wire [1:0]    m_axis_tuser_o;
  wire          m_axis_tlast_o;
  wire          cfg_ready_o;

  track_speed_limiter_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register shadow and batch accumulator of the speed predictor
  bit [31:0]       frame_prev_r, frame_last_r, t_first_r, t_second_r, max_gap_r;
  bit [30:0]       max_speed_r;
  bit              limit_r;
  int unsigned     batch_cnt;
  longint unsigned batch_sum;

  track_t pending_tracks[$];
  speed_t expected_speeds[$];
  int unsigned errors = 0;
  int unsigned tracks_in = 0;
  bit tx_idle = 1'b1, rx_idle = 1'b1, rx_hold = 1'b0;

  // Rounded quotient, ties away from zero, saturated to 32 bits signed
  function automatic longint div_round(longint n, longint d);
    bit neg;
    longint unsigned un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    if (ud == 0) return 0;
    q = (un + ud / 2) / ud;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return longint'(q);
  endfunction

  // Rounded integer square root
  function automatic longint unsigned root_round(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  function automatic longint unsigned vel_magnitude(longint vx, longint vy);
    longint unsigned ax, ay;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    return root_round(ax * ax + ay * ay);
  endfunction

  // Work out the result of one track and advance the batch accumulator
  function automatic speed_t predict_speed(track_t t);
    speed_t          r;
    longint          dt, vx, vy;
    longint unsigned gap, mag, spd, mean;
    bit              bad;
    vx = 0;
    vy = 0;
    mean = 0;
    dt = longint'(t_second_r) - longint'(t_first_r);
    gap = dt < 0 ? -dt : dt;
    if (limit_r) bad = dt == 0 || t_second_r == 0 || gap > longint'(max_gap_r);
    else bad = dt == 0 || t_first_r == 0 || t_second_r == 0;
    r.matched = t.has_two && t.newest_frame == frame_last_r && t.older_frame == frame_prev_r;
    if (r.matched && !bad) begin
      vx = div_round((longint'(t.nx) - longint'(t.ox)) * 16000000, dt);
      vy = div_round((longint'(t.ny) - longint'(t.oy)) * 16000000, dt);
      mag = vel_magnitude(vx, vy);
      if (limit_r && mag > longint'(max_speed_r)) begin
        vx = div_round(vx * longint'(max_speed_r), longint'(mag));
        vy = div_round(vy * longint'(max_speed_r), longint'(mag));
        mag = vel_magnitude(vx, vy);
      end
      spd = mag > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : mag;
      if (batch_cnt < tsl_pkg::MAX_TRACKS) begin
        batch_cnt++;
        batch_sum += spd;
      end
    end
    if (t.batch_end) begin
      if (!bad && batch_cnt > 0) mean = (batch_sum + batch_cnt / 2) / batch_cnt;
      if (mean > 64'h7FFF_FFFF) mean = 64'h7FFF_FFFF;
      batch_cnt = 0;
      batch_sum = 0;
    end
    r.vel_x = vx[31:0];
    r.vel_y = vy[31:0];
    r.mean_speed = mean[30:0];
    r.invalid = bad;
    r.last = t.batch_end;
    return r;
  endfunction

  // Drive tracks from the pending queue, predict on each accepted item
  int unsigned tx_wait = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        expected_speeds.insert(expected_speeds.size(),
                               predict_speed(pending_tracks.pop_front()));
        tracks_in++;
        tx_wait = tx_idle ? $urandom_range(0, 9) : 0;
      end
      if (s_valid && !s_axis_tready_o) begin
        // hold the offered item
      end else if (tx_wait > 0) begin
        tx_wait--;
        s_valid <= 1'b0;
      end else if (pending_tracks.size() > 0) begin
        s_valid <= 1'b1;
        s_data  <= {pending_tracks[0].ny, pending_tracks[0].nx, pending_tracks[0].oy,
                    pending_tracks[0].ox, pending_tracks[0].older_frame,
                    pending_tracks[0].newest_frame};
        s_user  <= pending_tracks[0].has_two;
        s_last  <= pending_tracks[0].batch_end;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Take results with random stalls and compare against the oldest prediction
  int unsigned rx_wait = 0;
  always @(posedge clk_i) begin
    speed_t e;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (expected_speeds.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", m_axis_tdata_o);
        end else begin
          e = expected_speeds.pop_front();
          if (m_axis_tdata_o[31:0] !== e.vel_x || m_axis_tdata_o[63:32] !== e.vel_y ||
              m_axis_tdata_o[94:64] !== e.mean_speed || m_axis_tuser_o[0] !== e.matched ||
              m_axis_tuser_o[1] !== e.invalid || m_axis_tlast_o !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp vx=%0d vy=%0d mean=%0d m=%b inv=%b last=%b",
                       $signed(e.vel_x), $signed(e.vel_y), e.mean_speed, e.matched,
                       e.invalid, e.last, "  got vx=%0d vy=%0d mean=%0d m=%b inv=%b last=%b",
                       $signed(m_axis_tdata_o[31:0]), $signed(m_axis_tdata_o[63:32]),
                       m_axis_tdata_o[94:64], m_axis_tuser_o[0], m_axis_tuser_o[1],
                       m_axis_tlast_o);
          end
        end
        rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_ready <= !rx_hold && rx_wait == 0;
    end
  end

  // Abort when no channel moves an item for too long
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
          (cfg_valid && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL track_speed_limiter_core");
        $finish;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering tracks
  initial begin
    while (tracks_in < 200) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      tsl_pkg::REG_FRAME_PREV:  frame_prev_r = v;
      tsl_pkg::REG_FRAME_LAST:  frame_last_r = v;
      tsl_pkg::REG_TIME_FIRST:  t_first_r    = v;
      tsl_pkg::REG_TIME_SECOND: t_second_r   = v;
      tsl_pkg::REG_MAX_SPEED:   max_speed_r  = v[30:0];
      tsl_pkg::REG_LIMIT_MODE:  limit_r      = v[0];
      tsl_pkg::REG_MAX_GAP:     max_gap_r    = v;
      default: ;
    endcase
  endtask

  // Let everything in flight drain before touching registers
  task automatic drain();
    while (pending_tracks.size() > 0 || expected_speeds.size() > 0 || s_valid)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic setup(bit [31:0] fp, bit [31:0] fl, bit [31:0] tf, bit [31:0] ts,
                       bit [31:0] ms, bit lm, bit [31:0] mg);
    drain();
    write_reg(tsl_pkg::REG_FRAME_PREV, fp);
    write_reg(tsl_pkg::REG_FRAME_LAST, fl);
    write_reg(tsl_pkg::REG_TIME_FIRST, tf);
    write_reg(tsl_pkg::REG_TIME_SECOND, ts);
    write_reg(tsl_pkg::REG_MAX_SPEED, ms);
    write_reg(tsl_pkg::REG_LIMIT_MODE, {31'b0, lm});
    write_reg(tsl_pkg::REG_MAX_GAP, mg);
  endtask

  // Queue one matched track with the given coordinates
  task automatic push_coords(bit [15:0] ox, bit [15:0] oy, bit [15:0] nx, bit [15:0] ny,
                             bit be);
    track_t t;
    t = '{1'b1, frame_last_r, frame_prev_r, ox, oy, nx, ny, be};
    pending_tracks.insert(pending_tracks.size(), t);
  endtask

  // Queue a random track, matched with the given percentage
  task automatic push_random(int unsigned match_pct, bit be);
    track_t t;
    t.has_two = 1'b1;
    t.newest_frame = frame_last_r;
    t.older_frame = frame_prev_r;
    if ($urandom_range(0, 99) >= match_pct) begin
      case ($urandom_range(0, 3))
        0: t.has_two = 1'b0;
        1: t.newest_frame = $urandom;
        2: t.older_frame = $urandom;
        default: begin
          t.has_two = 1'($urandom);
          t.newest_frame = $urandom;
          t.older_frame = $urandom;
        end
      endcase
    end
    t.ox = 16'($urandom);
    t.oy = 16'($urandom);
    if ($urandom_range(0, 1)) begin
      t.nx = 16'($urandom);
      t.ny = 16'($urandom);
    end else begin
      t.nx = t.ox + 16'($signed($urandom_range(0, 512)) - 256);
      t.ny = t.oy + 16'($signed($urandom_range(0, 512)) - 256);
    end
    t.batch_end = be;
    pending_tracks.insert(pending_tracks.size(), t);
  endtask

  // Random register set: mostly usable time pairs, with every rejection case
  task automatic random_setup();
    bit [31:0] tf, ts, ms, mg;
    tf = $urandom_range(1, 32'hF000_0000);
    ts = tf + $urandom_range(1, 200000);
    mg = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd1000000;
    case ($urandom_range(0, 9))
      0: {tf, ts} = {ts, tf};
      1: ts = tf;
      2: ts = 0;
      3: tf = 0;
      4: mg = ts - tf - 1;
      5: begin
        tf = $urandom;
        ts = $urandom;
        mg = $urandom;
      end
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: ms = 0;
      1: ms = 32'h7FFF_FFFF;
      2: ms = $urandom;
      default: ms = $urandom_range(1, 32'h0100_0000);
    endcase
    setup($urandom, $urandom, tf, ts, ms, $urandom_range(0, 3) != 0, mg);
    tx_idle = $urandom_range(0, 4) != 0;
    rx_idle = $urandom_range(0, 4) != 0;
  endtask

  initial begin
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    frame_prev_r = 0; frame_last_r = 0; t_first_r = 0; t_second_r = 0;
    max_speed_r = 0; limit_r = 1'b1; max_gap_r = 32'd1000000;
    batch_cnt = 0; batch_sum = 0;

    // Reset defaults: both times unknown, so the batch is rejected
    push_coords(16'd0, 16'd0, 16'd100, 16'd100, 1'b1);

    // Plain mode, one microsecond gap: velocities saturate both ways
    setup(32'd5, 32'hFFFF_FFFF, 32'd1000, 32'd1001, 32'd0, 1'b0, 32'd0);
    push_coords(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    push_coords(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    push_coords(16'h1234, 16'h1234, 16'h1234, 16'h1234, 1'b0);
    pending_tracks.insert(pending_tracks.size(),
                          '{1'b0, 32'hFFFF_FFFF, 32'd5, 16'd0, 16'd0, 16'd9, 16'd9, 1'b0});
    pending_tracks.insert(pending_tracks.size(),
                          '{1'b1, 32'd4, 32'd5, 16'd0, 16'd0, 16'd9, 16'd9, 1'b0});
    pending_tracks.insert(pending_tracks.size(),
                          '{1'b1, 32'hFFFF_FFFF, 32'd6, 16'd0, 16'd0, 16'd9, 16'd9, 1'b1});

    // Limit mode, time running backward, clamped velocities
    setup(32'hFFFF_FFFF, 32'd0, 32'd50000, 32'd10000, 32'd1000, 1'b1, 32'hFFFF_FFFF);
    push_coords(16'd0, 16'd0, 16'd3, 16'd4, 1'b0);
    push_coords(16'd500, 16'd500, 16'd500, 16'd500, 1'b0);
    push_coords(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1);

    // Limit zero: every moving track is clamped to a standstill
    setup(32'd7, 32'd8, 32'd1, 32'd2, 32'd0, 1'b1, 32'd1);
    push_coords(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1);

    // Gap larger than allowed, then a batch with no matches
    setup(32'd7, 32'd8, 32'd1, 32'd3, 32'd100, 1'b1, 32'd1);
    push_coords(16'd0, 16'd0, 16'd10, 16'd10, 1'b1);
    setup(32'd7, 32'd8, 32'd0, 32'd300, 32'h7FFF_FFFF, 1'b1, 32'd0);
    pending_tracks.insert(pending_tracks.size(),
                          '{1'b0, 32'd8, 32'd7, 16'd0, 16'd0, 16'd1, 16'd1, 1'b1});
    push_coords(16'd0, 16'd0, 16'd1, 16'd1, 1'b0);
    push_coords(16'd0, 16'd0, 16'd1, 16'd1, 1'b1);

    // One long batch that overflows the match counter
    setup($urandom, $urandom, 32'd100, 32'd1100, $urandom_range(1, 32'h0010_0000),
          1'($urandom_range(0, 1)), 32'd1000000);
    for (int i = 0; i < 1080; i++) begin
      push_random(95, i == 1079);
      if (i % 120 == 119) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
    end

    // Short random phases across register settings
    for (int p = 0; p < 10; p++) begin
      random_setup();
      n = $urandom_range(20, 40);
      for (int i = 0; i < n; i++)
        push_random(80, i == n - 1 || $urandom_range(0, 9) == 0);
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS track_speed_limiter_core");
    end else begin
      $display("FAIL track_speed_limiter_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/tsl_pkg.sv
rtl/tsl_iter_unit.sv
rtl/track_speed_limiter_core.sv
dv/tb_track_speed_limiter_core.sv
